### design/c_subset_lexer_unit_macros.svh
// Assertion macros shared by the lexer's checker.
`ifndef C_SUBSET_LEXER_UNIT_MACROS_SVH
`define C_SUBSET_LEXER_UNIT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define CSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define CSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/csl_pkg.sv
// Types and constants shared by the lexer modules.
`timescale 1ns / 1ps
`default_nettype none

package csl_pkg;

  localparam int TOK_START_W = 16;
  localparam int TOK_LEN_W   = 7;
  localparam int LIT_VALUE_W = 31;
  localparam logic [LIT_VALUE_W-1:0] LIT_MAX = 31'h7FFF_FFFF;

  // Result queue depth: one word waiting plus the three tokens one byte can give.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;
  localparam int MAX_TOKS = 3;

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_INT     = 4'd1,
    KIND_RETURN  = 4'd2,
    KIND_IDENT   = 4'd3,
    KIND_LIT     = 4'd4,
    KIND_LPAREN  = 4'd5,
    KIND_RPAREN  = 4'd6,
    KIND_LBRACE  = 4'd7,
    KIND_RBRACE  = 4'd8,
    KIND_SEMI    = 4'd9,
    KIND_UNKNOWN = 4'd10
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t              kind;
    logic [TOK_START_W-1:0] start;
    logic [TOK_LEN_W-1:0]   length;
    logic [LIT_VALUE_W-1:0] value;
  } tok_t;

  // Tokens one byte produces, in output order: flushed pending token,
  // then a punctuator/unknown or the end-of-text flush, then the end token.
  typedef struct packed {
    logic [MAX_TOKS-1:0]       vld;
    tok_t [MAX_TOKS-1:0]       tok;
  } lex_out_t;

  typedef struct packed {
    tok_t tok;
    logic last;
  } res_t;

endpackage

`default_nettype wire

### design/c_subset_lexer_unit.sv
// Top level of the C-subset lexer: byte input channel, token result channel.
//
// Usage: source text enters one byte per word on the in_ channel, with
// in_end_of_text high on the final byte of a text. Each accepted byte yields
// zero to three tokens on the out_ channel, one token per word, in source
// order; out_last_of_run marks the final token caused by a byte. Words and
// literals are reported when the byte that ends them arrives, so a token's
// report trails its last character by one byte. The end-of-text byte flushes
// any pending word or literal and adds an end token; positions then restart
// at zero for the next text.
// A byte's tokens enter the result queue when it is accepted and are offered
// once the words ahead of them are taken. Throughput: one byte per cycle while
// each byte causes at most one token and the receiver takes every word; a byte
// with more tokens holds back later bytes while the queue drains. The limit is
// the four-entry result queue, which accepts a byte only while it holds at
// most one token, so in_ready does not depend on out_ready. Reset
// (synchronous, active low) empties the queue and returns the lexer to idle
// with position zero. When the receiver stalls, the offered token holds steady
// and, once one more byte's tokens are queued, in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module c_subset_lexer_unit import csl_pkg::*; #(
  parameter int POS_WIDTH     = 16,
  parameter int MAX_TOKEN_LEN = 127
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_tok_kind,
  output logic [15:0]      out_tok_start,
  output logic [6:0]       out_tok_length,
  output logic [30:0]      out_lit_value,
  output logic             out_last_of_run
);

  logic     take;
  lex_out_t lex_out;
  res_t     out_res;

  // A valid byte is consumed while the queue holds at most one token, so all of its tokens fit.
  assign take = in_valid && in_ready;

  csl_core #(
    .POS_WIDTH     (POS_WIDTH),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .ch          (in_ch),
    .end_of_text (in_end_of_text),
    .lex_out     (lex_out)
  );

  csl_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .lex_out   (lex_out),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // Token fields go straight to their ports.
  assign out_tok_kind    = out_res.tok.kind;
  assign out_tok_start   = out_res.tok.start;
  assign out_tok_length  = out_res.tok.length;
  assign out_lit_value   = out_res.tok.value;
  assign out_last_of_run = out_res.last;

endmodule

`default_nettype wire

### design/csl_core.sv
// Token state machine: consumes one byte and yields up to three tokens.
`timescale 1ns / 1ps
`default_nettype none

module csl_core import csl_pkg::*; #(
  parameter int POS_WIDTH     = 16,
  parameter int MAX_TOKEN_LEN = 127
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] ch,
  input  wire logic       end_of_text,
  output lex_out_t        lex_out
);

  localparam int LenW    = $clog2(MAX_TOKEN_LEN + 1);
  localparam int LenExtW = (LenW > TOK_LEN_W) ? LenW : TOK_LEN_W;
  localparam int PosExtW = (POS_WIDTH > TOK_START_W) ? POS_WIDTH : TOK_START_W;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_WORD = 3'b010,
    MODE_NUM  = 3'b100
  } mode_t;

  mode_t                  mode_r,  mode_nxt;
  logic [LenW-1:0]        len_r,   len_nxt;
  logic [LIT_VALUE_W-1:0] val_r,   val_nxt;
  logic [POS_WIDTH-1:0]   start_r, start_nxt;
  logic [POS_WIDTH-1:0]   pos_r,   pos_nxt;
  logic [1:0]             hits_r,  hits_nxt;

  mode_t                  mode_g;
  logic [LenW-1:0]        len_g;
  logic [LIT_VALUE_W-1:0] val_g;
  logic [POS_WIDTH-1:0]   start_g;
  logic [1:0]             hits_g;
  logic                   taken;
  logic                   c_space, c_alpha, c_digit, c_under;
  logic                   a_vld, b_vld, c_vld;
  tok_t                   a_tok, b_tok, c_tok, d_tok;

  function automatic logic [7:0] kw_int_char(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h69;  // i
      2'd1:    r = 8'h6E;  // n
      default: r = 8'h74;  // t
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_ret_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h72;  // r
      3'd1:    r = 8'h65;  // e
      3'd2:    r = 8'h74;  // t
      3'd3:    r = 8'h75;  // u
      3'd4:    r = 8'h72;  // r
      default: r = 8'h6E;  // n
    endcase
    return r;
  endfunction

  // Drops each keyword candidate whose next letter does not match.
  function automatic logic [1:0] word_hits(input logic [LenW-1:0] len,
                                           input logic [1:0] hits,
                                           input logic [7:0] c);
    logic [1:0] h;
    h = hits;
    if (!(len < LenW'(3) && c == kw_int_char(len[1:0]))) h[0] = 1'b0;
    if (!(len < LenW'(6) && c == kw_ret_char(len[2:0]))) h[1] = 1'b0;
    return h;
  endfunction

  function automatic logic [LenW-1:0] len_inc(input logic [LenW-1:0] len);
    return (len < LenW'(MAX_TOKEN_LEN)) ? LenW'(len + 1'b1) : len;
  endfunction

  // value * 10 + digit, saturating.
  function automatic logic [LIT_VALUE_W-1:0] num_grow(input logic [LIT_VALUE_W-1:0] v,
                                                      input logic [3:0] d);
    logic [LIT_VALUE_W+3:0] t;
    t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{LIT_VALUE_W{1'b0}}, d};
    return (t > {4'b0, LIT_MAX}) ? LIT_MAX : t[LIT_VALUE_W-1:0];
  endfunction

  function automatic logic [TOK_START_W-1:0] to_start(input logic [POS_WIDTH-1:0] p);
    logic [PosExtW-1:0] e;
    e = PosExtW'(p);
    return e[TOK_START_W-1:0];
  endfunction

  function automatic logic [TOK_LEN_W-1:0] to_len(input logic [LenW-1:0] l);
    logic [LenExtW-1:0] e;
    e = LenExtW'(l);
    return e[TOK_LEN_W-1:0];
  endfunction

  function automatic tok_t flush_tok(input mode_t m, input logic [LenW-1:0] len,
                                     input logic [LIT_VALUE_W-1:0] v,
                                     input logic [POS_WIDTH-1:0] st,
                                     input logic [1:0] hits);
    tok_t t;
    t.start  = to_start(st);
    t.length = to_len(len);
    t.value  = '0;
    if (m == MODE_NUM) begin
      t.kind  = KIND_LIT;
      t.value = v;
    end else if (hits[0] && len == LenW'(3)) begin
      t.kind = KIND_INT;
    end else if (hits[1] && len == LenW'(6)) begin
      t.kind = KIND_RETURN;
    end else begin
      t.kind = KIND_IDENT;
    end
    return t;
  endfunction

  function automatic tok_kind_t punct_kind(input logic [7:0] c);
    tok_kind_t k;
    case (c)
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  always_comb begin
    c_space = (ch == 8'h20) || (ch >= 8'h09 && ch <= 8'h0D);
    c_alpha = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    c_digit = (ch >= 8'h30 && ch <= 8'h39);
    c_under = (ch == CH_UNDER);

    mode_g  = mode_r;
    len_g   = len_r;
    val_g   = val_r;
    start_g = start_r;
    hits_g  = hits_r;
    taken   = 1'b0;
    a_vld   = 1'b0;
    a_tok   = flush_tok(mode_r, len_r, val_r, start_r, hits_r);

    // Extend the pending token, or flush it.
    unique case (mode_r)
      MODE_WORD: begin
        if (c_alpha || c_digit || c_under) begin
          hits_g = word_hits(len_r, hits_r, ch);
          len_g  = len_inc(len_r);
          taken  = 1'b1;
        end else begin
          a_vld = 1'b1;
        end
      end
      MODE_NUM: begin
        if (c_digit) begin
          val_g = num_grow(val_r, ch[3:0]);
          len_g = len_inc(len_r);
          taken = 1'b1;
        end else begin
          a_vld = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (a_vld) begin
      mode_g = MODE_IDLE;
      len_g  = '0;
      val_g  = '0;
      hits_g = 2'b11;
    end

    // A non-space byte not absorbed above starts a token or is one.
    b_vld        = 1'b0;
    b_tok.kind   = punct_kind(ch);
    b_tok.start  = to_start(pos_r);
    b_tok.length = TOK_LEN_W'(1);
    b_tok.value  = '0;
    if (!taken && !c_space) begin
      if (c_alpha || c_under) begin
        mode_g  = MODE_WORD;
        start_g = pos_r;
        len_g   = LenW'(1);
        val_g   = '0;
        hits_g  = word_hits('0, 2'b11, ch);
      end else if (c_digit) begin
        mode_g  = MODE_NUM;
        start_g = pos_r;
        len_g   = LenW'(1);
        val_g   = {{(LIT_VALUE_W-4){1'b0}}, ch[3:0]};
      end else begin
        b_vld = 1'b1;
      end
    end

    // End of text flushes whatever is pending and appends the end token.
    c_vld = end_of_text && (mode_g != MODE_IDLE);
    c_tok = flush_tok(mode_g, len_g, val_g, start_g, hits_g);

    d_tok.kind   = KIND_END;
    d_tok.start  = to_start(POS_WIDTH'(pos_r + 1'b1));
    d_tok.length = '0;
    d_tok.value  = '0;

    mode_nxt  = mode_g;
    len_nxt   = len_g;
    val_nxt   = val_g;
    start_nxt = start_g;
    hits_nxt  = hits_g;
    pos_nxt   = POS_WIDTH'(pos_r + 1'b1);
    if (end_of_text) begin
      mode_nxt = MODE_IDLE;
      len_nxt  = '0;
      val_nxt  = '0;
      hits_nxt = 2'b11;
      pos_nxt  = '0;
    end

    lex_out.vld    = {take && end_of_text, take && (b_vld || c_vld), take && a_vld};
    lex_out.tok[0] = a_tok;
    lex_out.tok[1] = b_vld ? b_tok : c_tok;
    lex_out.tok[2] = d_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      len_r   <= '0;
      val_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
      hits_r  <= 2'b11;
    end else if (take) begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      val_r   <= val_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      hits_r  <= hits_nxt;
    end
  end

endmodule

`default_nettype wire

### design/csl_out_queue.sv
// Four-entry token queue that packs a byte's tokens and drains one per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module csl_out_queue import csl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire lex_out_t lex_out,
  output logic          space_ok,
  output logic          out_valid,
  input  wire logic     out_ready,
  output res_t          out_res
);

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]        n_new;
  logic              pop;
  tok_t              items [MAX_TOKS];

  always_comb begin
    n_new = {1'b0, lex_out.vld[0]} + {1'b0, lex_out.vld[1]} + {1'b0, lex_out.vld[2]};

    items[0] = lex_out.vld[0] ? lex_out.tok[0] :
               (lex_out.vld[1] ? lex_out.tok[1] : lex_out.tok[2]);
    items[1] = (lex_out.vld[0] && lex_out.vld[1]) ? lex_out.tok[1] : lex_out.tok[2];
    items[2] = lex_out.tok[2];

    out_valid = (cnt_r != '0);
    out_res   = q_r[rd_r];
    pop       = out_valid && out_ready;
    // Room for a full run of tokens behind at most one waiting word.
    space_ok  = (cnt_r <= QCNT_W'(1));

    rd_nxt  = QPTR_W'(rd_r + {{(QPTR_W-1){1'b0}}, pop});
    wr_nxt  = push ? QPTR_W'(wr_r + n_new) : wr_r;
    cnt_nxt = QCNT_W'(cnt_r + (push ? {1'b0, n_new} : 3'd0) - {2'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MAX_TOKS; i++) begin
        if (2'(i) < n_new) begin
          q_r[QPTR_W'(wr_r + QPTR_W'(i))].tok  <= items[i];
          q_r[QPTR_W'(wr_r + QPTR_W'(i))].last <= (2'(i) == 2'(n_new - 2'd1));
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/csl_checker.sv
// Port-level checks for the lexer and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
`include "c_subset_lexer_unit_macros.svh"

module csl_checker import csl_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  in_ch,
  input wire logic        in_end_of_text,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_tok_kind,
  input wire logic [15:0] out_tok_start,
  input wire logic [6:0]  out_tok_length,
  input wire logic [30:0] out_lit_value,
  input wire logic        out_last_of_run
);

  logic        in_stall;
  logic        out_stall;
  logic [8:0]  in_word;
  logic [58:0] out_word;
  logic        is_end;
  logic        end_ok;
  logic        one_char;
  logic        len_one;
  logic        non_lit;
  logic        value_zero;

  assign in_stall   = in_valid && !in_ready;
  assign out_stall  = out_valid && !out_ready;
  assign in_word    = {in_ch, in_end_of_text};
  assign out_word   = {out_tok_kind, out_tok_start, out_tok_length, out_lit_value,
                       out_last_of_run};
  assign value_zero = (out_lit_value == 31'd0);
  assign is_end     = out_valid && (out_tok_kind == KIND_END);
  assign end_ok     = out_last_of_run && (out_tok_length == 7'd0) && value_zero;
  assign one_char   = out_valid && ((out_tok_kind == KIND_LPAREN) ||
                                    (out_tok_kind == KIND_RPAREN) ||
                                    (out_tok_kind == KIND_LBRACE) ||
                                    (out_tok_kind == KIND_RBRACE) ||
                                    (out_tok_kind == KIND_SEMI)   ||
                                    (out_tok_kind == KIND_UNKNOWN));
  assign len_one    = (out_tok_length == 7'd1);
  assign non_lit    = out_valid && (out_tok_kind != KIND_LIT);

  // A waiting byte must hold still until it is taken.
  `CSL_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(in_word), "waiting byte changed")

  // A stalled token word must hold still.
  `CSL_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled token changed")

  // The end token closes its byte's run and is empty.
  `CSL_ASSERT_NOW(a_end_token, is_end, end_ok, "malformed end token")

  // Punctuators and unknown bytes are single characters.
  `CSL_ASSERT_NOW(a_single_char, one_char, len_one, "single-character token with wrong length")

  // Only literals carry a value.
  `CSL_ASSERT_NOW(a_value_lit_only, non_lit, value_zero, "value on a non-literal token")

endmodule

bind c_subset_lexer_unit csl_checker u_csl_checker (.*);

`default_nettype wire
